>>> hw/rtl/cci_pkg.sv
`default_nettype none
package cci_pkg;

   localparam logic [16:0] RESTITUTION_RESET = 17'd52429;
   localparam logic [30:0] THRESHOLD_RESET   = 31'd1310720;

   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] REG_RESTITUTION = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD   = 4'd1;

   typedef struct packed {
      logic signed [31:0] pax;
      logic signed [31:0] pay;
      logic signed [31:0] vax;
      logic signed [31:0] vay;
      logic [30:0]        ra;
      logic [31:0]        ima;
      logic signed [31:0] pbx;
      logic signed [31:0] pby;
      logic signed [31:0] vbx;
      logic signed [31:0] vby;
      logic [30:0]        rb;
      logic [31:0]        imb;
   } item_type;

   typedef struct packed {
      logic signed [31:0] pax;
      logic signed [31:0] pay;
      logic signed [31:0] vax;
      logic signed [31:0] vay;
      logic signed [31:0] pbx;
      logic signed [31:0] pby;
      logic signed [31:0] vbx;
      logic signed [31:0] vby;
      logic               collided;
   } result_type;

endpackage
`default_nettype wire

>>> hw/rtl/cci_datapath.sv
`default_nettype none
module cci_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire cci_pkg::item_type    in_item,
   input  wire logic [16:0]          restitution,
   input  wire logic [30:0]          bounce_threshold,
   output logic                      in_ready,
   output logic                      out_valid,
   output cci_pkg::result_type       out_res
);

   localparam int SQ_STEPS = 33;
   localparam int FA_STEPS = 25;
   localparam int ST_A  = 0;
   localparam int ST_B  = 1;
   localparam int ST_SQ = 2;
   localparam int ST_D  = ST_SQ + SQ_STEPS + 1;
   localparam int ST_DV = ST_D + 1;
   localparam int ST_E  = ST_DV + FRAC_BITS + 1;
   localparam int ST_G  = ST_E + 1;
   localparam int ST_H  = ST_G + 1;
   localparam int ST_I  = ST_H + 1;
   localparam int ST_J  = ST_I + 1;
   localparam int ST_K  = ST_J + 1;
   localparam int ST_L  = ST_K + 1;
   localparam int ST_M  = ST_L + 1;
   localparam int NST   = ST_M + 1;
   localparam int PW    = FRAC_BITS + 34;   // n times push
   localparam int VW    = FRAC_BITS + 35;   // rel velocity dot n
   localparam int KW    = FRAC_BITS + 38;   // impulse times n
   localparam logic [32:0] NUDGE_M = 33'(((1 << FRAC_BITS) + 50) / 100);
   localparam logic signed [39:0] SAT_MAX = 40'sh007fffffff;
   localparam logic signed [39:0] SAT_MIN = 40'shff80000000;

   typedef struct packed {
      cci_pkg::item_type         it;
      logic signed [32:0]        dx;
      logic signed [32:0]        dy;
      logic [32:0]               sum;
      logic [31:0]               sumr;
      logic [63:0]               sqx;
      logic [63:0]               sqy;
      logic [65:0]               rad;
      logic [34:0]               srem;
      logic [32:0]               root;
      logic [32:0]               arem;
      logic [32:0]               brem;
      logic [24:0]               fa;
      logic [24:0]               fb;
      logic                      collided;
      logic                      sumnz;
      logic [32:0]               dxm;
      logic [32:0]               dym;
      logic                      dxn;
      logic                      dyn;
      logic [32:0]               cdist;
      logic signed [33:0]        overlap;
      logic [32:0]               xrem;
      logic [32:0]               yrem;
      logic [FRAC_BITS:0]        nxm;
      logic [FRAC_BITS:0]        nym;
      logic [32:0]               pam;
      logic [32:0]               pbm;
      logic signed [32:0]        rvx;
      logic signed [32:0]        rvy;
      logic signed [33:0]        dpax;
      logic signed [33:0]        dpay;
      logic signed [33:0]        dpbx;
      logic signed [33:0]        dpby;
      logic signed [VW-1:0]      pvx;
      logic signed [VW-1:0]      pvy;
      logic [34:0]               vanm;
      logic                      van_neg;
      logic                      approach;
      logic [16:0]               e;
      logic [36:0]               jm;
      logic [36:0]               kam;
      logic [36:0]               kbm;
      logic signed [37:0]        dvax;
      logic signed [37:0]        dvay;
      logic signed [37:0]        dvbx;
      logic signed [37:0]        dvby;
   } pl_type;

   pl_type           pl_ff [NST];
   pl_type           pl_in [NST];
   logic [NST-1:0]   v_ff;
   logic             ld0;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7fffffff;
      end else if (v < SAT_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   assign ld0       = en || !v_ff[0];
   assign in_ready  = ld0;
   assign out_valid = v_ff[NST-1];

   always_comb begin
      out_res.pax      = pl_ff[NST-1].it.pax;
      out_res.pay      = pl_ff[NST-1].it.pay;
      out_res.vax      = pl_ff[NST-1].it.vax;
      out_res.vay      = pl_ff[NST-1].it.vay;
      out_res.pbx      = pl_ff[NST-1].it.pbx;
      out_res.pby      = pl_ff[NST-1].it.pby;
      out_res.vbx      = pl_ff[NST-1].it.vbx;
      out_res.vby      = pl_ff[NST-1].it.vby;
      out_res.collided = pl_ff[NST-1].collided;
   end

   // entry: differences and sums
   always_comb begin
      pl_in[ST_A]      = '0;
      pl_in[ST_A].it   = in_item;
      pl_in[ST_A].dx   = 33'($signed(in_item.pax)) - 33'($signed(in_item.pbx));
      pl_in[ST_A].dy   = 33'($signed(in_item.pay)) - 33'($signed(in_item.pby));
      pl_in[ST_A].sum  = 33'(in_item.ima) + 33'(in_item.imb);
      pl_in[ST_A].sumr = 32'(in_item.ra) + 32'(in_item.rb);
   end

   for (genvar s = 1; s < NST; s++) begin : g_st
      if (s == ST_B) begin : g_sq
         logic [31:0] mx, my;
         always_comb begin
            pl_in[s]     = pl_ff[s-1];
            mx           = 32'(pl_ff[s-1].dx[32] ? -pl_ff[s-1].dx : pl_ff[s-1].dx);
            my           = 32'(pl_ff[s-1].dy[32] ? -pl_ff[s-1].dy : pl_ff[s-1].dy);
            pl_in[s].sqx = 64'(mx) * 64'(mx);
            pl_in[s].sqy = 64'(my) * 64'(my);
         end
      end else if (s == ST_SQ) begin : g_rad
         always_comb begin
            pl_in[s]      = pl_ff[s-1];
            pl_in[s].rad  = 66'(pl_ff[s-1].sqx) + 66'(pl_ff[s-1].sqy);
            pl_in[s].srem = '0;
            pl_in[s].root = '0;
            pl_in[s].arem = 33'(pl_ff[s-1].it.ima[31:1]);
            pl_in[s].brem = 33'(pl_ff[s-1].it.imb[31:1]);
            pl_in[s].fa   = '0;
            pl_in[s].fb   = '0;
         end
      end else if (s > ST_SQ && s < ST_D) begin : g_root
         // one root digit per stage; the mass shares divide alongside
         localparam int I  = s - ST_SQ - 1;
         localparam int QB = (I < FA_STEPS) ? FA_STEPS - 1 - I : 0;
         logic [36:0] t, tr;
         logic [33:0] ta, tb, dn;
         logic        nb_a, nb_b;
         always_comb begin
            pl_in[s] = pl_ff[s-1];
            t  = {pl_ff[s-1].srem, pl_ff[s-1].rad[65-2*I -: 2]};
            tr = {2'b00, pl_ff[s-1].root, 2'b01};
            if (t >= tr) begin
               pl_in[s].srem = 35'(t - tr);
               pl_in[s].root = {pl_ff[s-1].root[31:0], 1'b1};
            end else begin
               pl_in[s].srem = t[34:0];
               pl_in[s].root = {pl_ff[s-1].root[31:0], 1'b0};
            end
            nb_a = (I == 0) ? pl_ff[s-1].it.ima[0] : 1'b0;
            nb_b = (I == 0) ? pl_ff[s-1].it.imb[0] : 1'b0;
            dn   = {1'b0, pl_ff[s-1].sum};
            ta   = {pl_ff[s-1].arem, nb_a};
            tb   = {pl_ff[s-1].brem, nb_b};
            if (I < FA_STEPS) begin
               if (ta >= dn) begin
                  pl_in[s].arem   = 33'(ta - dn);
                  pl_in[s].fa[QB] = 1'b1;
               end else begin
                  pl_in[s].arem   = ta[32:0];
               end
               if (tb >= dn) begin
                  pl_in[s].brem   = 33'(tb - dn);
                  pl_in[s].fb[QB] = 1'b1;
               end else begin
                  pl_in[s].brem   = tb[32:0];
               end
            end
         end
      end else if (s == ST_D) begin : g_hit
         logic              nudge;
         logic [32:0]       ax, ay, cdist;
         always_comb begin
            pl_in[s]          = pl_ff[s-1];
            pl_in[s].collided = pl_ff[s-1].root < {1'b0, pl_ff[s-1].sumr};
            pl_in[s].sumnz    = pl_ff[s-1].sum != '0;
            // coincident centres: push A along x by the nudge
            nudge = (pl_ff[s-1].root < {1'b0, pl_ff[s-1].sumr}) && (pl_ff[s-1].root == '0);
            ax    = pl_ff[s-1].dx[32] ? 33'(-pl_ff[s-1].dx) : 33'(pl_ff[s-1].dx);
            ay    = pl_ff[s-1].dy[32] ? 33'(-pl_ff[s-1].dy) : 33'(pl_ff[s-1].dy);
            cdist = nudge ? NUDGE_M : pl_ff[s-1].root;
            if (nudge) begin
               pl_in[s].it.pax = sat32(40'($signed(pl_ff[s-1].it.pax)) + 40'(NUDGE_M));
            end
            pl_in[s].dxm     = nudge ? NUDGE_M : ax;
            pl_in[s].dxn     = nudge ? 1'b0 : pl_ff[s-1].dx[32];
            pl_in[s].dym     = nudge ? '0 : ay;
            pl_in[s].dyn     = nudge ? 1'b0 : pl_ff[s-1].dy[32];
            pl_in[s].cdist   = cdist;
            pl_in[s].overlap = $signed({2'b00, pl_ff[s-1].sumr}) - $signed({1'b0, cdist});
            pl_in[s].xrem    = 33'((nudge ? NUDGE_M : ax) >> 1);
            pl_in[s].yrem    = 33'((nudge ? 33'd0 : ay) >> 1);
            pl_in[s].nxm     = '0;
            pl_in[s].nym     = '0;
         end
      end else if (s >= ST_DV && s < ST_E) begin : g_norm
         // unit normal, one quotient bit per stage
         localparam int J  = s - ST_DV;
         localparam int QX = FRAC_BITS - J;
         logic [33:0] tx, ty, dn;
         always_comb begin
            pl_in[s] = pl_ff[s-1];
            dn = {1'b0, pl_ff[s-1].cdist};
            tx = {pl_ff[s-1].xrem, (J == 0) ? pl_ff[s-1].dxm[0] : 1'b0};
            ty = {pl_ff[s-1].yrem, (J == 0) ? pl_ff[s-1].dym[0] : 1'b0};
            if (tx >= dn) begin
               pl_in[s].xrem    = 33'(tx - dn);
               pl_in[s].nxm[QX] = 1'b1;
            end else begin
               pl_in[s].xrem    = tx[32:0];
            end
            if (ty >= dn) begin
               pl_in[s].yrem    = 33'(ty - dn);
               pl_in[s].nym[QX] = 1'b1;
            end else begin
               pl_in[s].yrem    = ty[32:0];
            end
         end
      end else if (s == ST_E) begin : g_push
         logic [32:0] ovm;
         always_comb begin
            pl_in[s] = pl_ff[s-1];
            ovm = pl_ff[s-1].overlap[33] ? 33'(-pl_ff[s-1].overlap)
                                         : 33'(pl_ff[s-1].overlap);
            pl_in[s].pam = 33'((58'(ovm) * 58'(pl_ff[s-1].fa)) >> 24);
            pl_in[s].pbm = 33'((58'(ovm) * 58'(pl_ff[s-1].fb)) >> 24);
            pl_in[s].rvx = 33'($signed(pl_ff[s-1].it.vax)) - 33'($signed(pl_ff[s-1].it.vbx));
            pl_in[s].rvy = 33'($signed(pl_ff[s-1].it.vay)) - 33'($signed(pl_ff[s-1].it.vby));
         end
      end else if (s == ST_G) begin : g_prod
         logic [32:0]     m_ax, m_ay, m_bx, m_by;
         logic [31:0]     rxm, rym;
         logic [VW-1:0]   mvx, mvy;
         logic            ovn;
         always_comb begin
            pl_in[s] = pl_ff[s-1];
            ovn  = pl_ff[s-1].overlap[33];
            m_ax = 33'((PW'(pl_ff[s-1].nxm) * PW'(pl_ff[s-1].pam)) >> FRAC_BITS);
            m_ay = 33'((PW'(pl_ff[s-1].nym) * PW'(pl_ff[s-1].pam)) >> FRAC_BITS);
            m_bx = 33'((PW'(pl_ff[s-1].nxm) * PW'(pl_ff[s-1].pbm)) >> FRAC_BITS);
            m_by = 33'((PW'(pl_ff[s-1].nym) * PW'(pl_ff[s-1].pbm)) >> FRAC_BITS);
            pl_in[s].dpax = $signed((pl_ff[s-1].dxn ^ ovn) ? -34'(m_ax) : 34'(m_ax));
            pl_in[s].dpay = $signed((pl_ff[s-1].dyn ^ ovn) ? -34'(m_ay) : 34'(m_ay));
            pl_in[s].dpbx = $signed((pl_ff[s-1].dxn ^ ovn) ? -34'(m_bx) : 34'(m_bx));
            pl_in[s].dpby = $signed((pl_ff[s-1].dyn ^ ovn) ? -34'(m_by) : 34'(m_by));
            rxm = 32'(pl_ff[s-1].rvx[32] ? -pl_ff[s-1].rvx : pl_ff[s-1].rvx);
            rym = 32'(pl_ff[s-1].rvy[32] ? -pl_ff[s-1].rvy : pl_ff[s-1].rvy);
            mvx = VW'(rxm) * VW'(pl_ff[s-1].nxm);
            mvy = VW'(rym) * VW'(pl_ff[s-1].nym);
            pl_in[s].pvx = $signed((pl_ff[s-1].rvx[32] ^ pl_ff[s-1].dxn) ? -mvx : mvx);
            pl_in[s].pvy = $signed((pl_ff[s-1].rvy[32] ^ pl_ff[s-1].dyn) ? -mvy : mvy);
         end
      end else if (s == ST_H) begin : g_pos
         logic signed [VW-1:0] dot;
         logic [VW-1:0]        dabs;
         always_comb begin
            pl_in[s] = pl_ff[s-1];
            dot  = pl_ff[s-1].pvx + pl_ff[s-1].pvy;
            dabs = dot[VW-1] ? VW'(-dot) : VW'(dot);
            pl_in[s].vanm     = 35'(dabs >> FRAC_BITS);
            pl_in[s].van_neg  = dot[VW-1];
            pl_in[s].approach = dot[VW-1] || ((dabs >> FRAC_BITS) == '0);
            if (pl_ff[s-1].collided && pl_ff[s-1].sumnz) begin
               pl_in[s].it.pax = sat32(40'($signed(pl_ff[s-1].it.pax)) + 40'(pl_ff[s-1].dpax));
               pl_in[s].it.pay = sat32(40'($signed(pl_ff[s-1].it.pay)) + 40'(pl_ff[s-1].dpay));
               pl_in[s].it.pbx = sat32(40'($signed(pl_ff[s-1].it.pbx)) - 40'(pl_ff[s-1].dpbx));
               pl_in[s].it.pby = sat32(40'($signed(pl_ff[s-1].it.pby)) - 40'(pl_ff[s-1].dpby));
            end
         end
      end else if (s == ST_I) begin : g_rest
         logic signed [36:0] vs, thn;
         always_comb begin
            pl_in[s] = pl_ff[s-1];
            vs  = $signed(pl_ff[s-1].van_neg ? -37'(pl_ff[s-1].vanm) : 37'(pl_ff[s-1].vanm));
            thn = -$signed(37'(bounce_threshold));
            // slow approach: no bounce
            pl_in[s].e = (vs > thn) ? 17'd0 : restitution;
         end
      end else if (s == ST_J) begin : g_imp
         always_comb begin
            pl_in[s]    = pl_ff[s-1];
            pl_in[s].jm = 37'((53'(pl_ff[s-1].vanm) *
                               53'(18'h10000 + 18'(pl_ff[s-1].e))) >> 16);
         end
      end else if (s == ST_K) begin : g_share
         always_comb begin
            pl_in[s]     = pl_ff[s-1];
            pl_in[s].kam = 37'((62'(pl_ff[s-1].jm) * 62'(pl_ff[s-1].fa)) >> 24);
            pl_in[s].kbm = 37'((62'(pl_ff[s-1].jm) * 62'(pl_ff[s-1].fb)) >> 24);
         end
      end else if (s == ST_L) begin : g_kick
         logic [36:0] m_ax, m_ay, m_bx, m_by;
         always_comb begin
            pl_in[s] = pl_ff[s-1];
            m_ax = 37'((KW'(pl_ff[s-1].kam) * KW'(pl_ff[s-1].nxm)) >> FRAC_BITS);
            m_ay = 37'((KW'(pl_ff[s-1].kam) * KW'(pl_ff[s-1].nym)) >> FRAC_BITS);
            m_bx = 37'((KW'(pl_ff[s-1].kbm) * KW'(pl_ff[s-1].nxm)) >> FRAC_BITS);
            m_by = 37'((KW'(pl_ff[s-1].kbm) * KW'(pl_ff[s-1].nym)) >> FRAC_BITS);
            pl_in[s].dvax = $signed(pl_ff[s-1].dxn ? -38'(m_ax) : 38'(m_ax));
            pl_in[s].dvay = $signed(pl_ff[s-1].dyn ? -38'(m_ay) : 38'(m_ay));
            pl_in[s].dvbx = $signed(pl_ff[s-1].dxn ? -38'(m_bx) : 38'(m_bx));
            pl_in[s].dvby = $signed(pl_ff[s-1].dyn ? -38'(m_by) : 38'(m_by));
         end
      end else begin : g_vel
         always_comb begin
            pl_in[s] = pl_ff[s-1];
            if (pl_ff[s-1].collided && pl_ff[s-1].sumnz && pl_ff[s-1].approach) begin
               pl_in[s].it.vax = sat32(40'($signed(pl_ff[s-1].it.vax)) + 40'(pl_ff[s-1].dvax));
               pl_in[s].it.vay = sat32(40'($signed(pl_ff[s-1].it.vay)) + 40'(pl_ff[s-1].dvay));
               pl_in[s].it.vbx = sat32(40'($signed(pl_ff[s-1].it.vbx)) - 40'(pl_ff[s-1].dvbx));
               pl_in[s].it.vby = sat32(40'($signed(pl_ff[s-1].it.vby)) - 40'(pl_ff[s-1].dvby));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ld0) begin
            v_ff[0] <= in_valid;
         end
         if (en) begin
            v_ff[NST-1:1] <= v_ff[NST-2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld0) begin
         pl_ff[0] <= pl_in[0];
      end
      if (en) begin
         for (int k = 1; k < NST; k++) begin
            pl_ff[k] <= pl_in[k];
         end
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/circle_collision_impulse_top.sv
`default_nettype none
// Circle pair collision resolver, Q16.16 by default.
// req_*: one word per circle pair (positions, velocities, radii, inverse
//   masses of A and B), valid/ready.
// rsp_*: one word per pair: corrected positions and velocities plus the
//   collided flag, valid/ready, in the order the pairs came in.
// csr_*: register writes (index 0 restitution, 1 bounce threshold); always
//   ready, other indexes are dropped. Write only while the block is empty.
// Throughput: one pair per cycle unless a stall holds the pipe. The depth comes from the 33-stage square
//   root, one root digit a stage, and the FRAC_BITS+1 stage normal divider.
// Stall: while rsp_valid waits on rsp_ready the whole pipe holds; the entry
//   stage still takes a word if it is empty, nothing is dropped or repeated.
// Reset (synchronous): empties the pipe and loads restitution 0.8 and
//   threshold 20.0.
module circle_collision_impulse_top #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [31:0]                  req_pos_a_x,
   input  wire logic signed [31:0]                  req_pos_a_y,
   input  wire logic signed [31:0]                  req_vel_a_x,
   input  wire logic signed [31:0]                  req_vel_a_y,
   input  wire logic [30:0]                         req_radius_a,
   input  wire logic [31:0]                         req_inv_mass_a,
   input  wire logic signed [31:0]                  req_pos_b_x,
   input  wire logic signed [31:0]                  req_pos_b_y,
   input  wire logic signed [31:0]                  req_vel_b_x,
   input  wire logic signed [31:0]                  req_vel_b_y,
   input  wire logic [30:0]                         req_radius_b,
   input  wire logic [31:0]                         req_inv_mass_b,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [31:0]                       rsp_new_pos_a_x,
   output logic signed [31:0]                       rsp_new_pos_a_y,
   output logic signed [31:0]                       rsp_new_vel_a_x,
   output logic signed [31:0]                       rsp_new_vel_a_y,
   output logic signed [31:0]                       rsp_new_pos_b_x,
   output logic signed [31:0]                       rsp_new_pos_b_y,
   output logic signed [31:0]                       rsp_new_vel_b_x,
   output logic signed [31:0]                       rsp_new_vel_b_y,
   output logic                                     rsp_collided,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [cci_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [31:0]                         csr_wdata
);

   logic [16:0]          restitution_ff;
   logic [30:0]          threshold_ff;
   logic                 en;
   logic                 out_valid;
   cci_pkg::item_type    item;
   cci_pkg::result_type  res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         restitution_ff <= cci_pkg::RESTITUTION_RESET;
         threshold_ff   <= cci_pkg::THRESHOLD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            cci_pkg::REG_RESTITUTION: restitution_ff <= csr_wdata[16:0];
            cci_pkg::REG_THRESHOLD:   threshold_ff   <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      item.pax = req_pos_a_x;
      item.pay = req_pos_a_y;
      item.vax = req_vel_a_x;
      item.vay = req_vel_a_y;
      item.ra  = req_radius_a;
      item.ima = req_inv_mass_a;
      item.pbx = req_pos_b_x;
      item.pby = req_pos_b_y;
      item.vbx = req_vel_b_x;
      item.vby = req_vel_b_y;
      item.rb  = req_radius_b;
      item.imb = req_inv_mass_b;
   end

   // pipe advances whenever the last stage is empty or being taken
   assign en = !out_valid || rsp_ready;

   cci_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .en               (en),
      .in_valid         (req_valid),
      .in_item          (item),
      .restitution      (restitution_ff),
      .bounce_threshold (threshold_ff),
      .in_ready         (req_ready),
      .out_valid        (out_valid),
      .out_res          (res)
   );

   assign rsp_valid       = out_valid;
   assign rsp_new_pos_a_x = res.pax;
   assign rsp_new_pos_a_y = res.pay;
   assign rsp_new_vel_a_x = res.vax;
   assign rsp_new_vel_a_y = res.vay;
   assign rsp_new_pos_b_x = res.pbx;
   assign rsp_new_pos_b_y = res.pby;
   assign rsp_new_vel_b_x = res.vbx;
   assign rsp_new_vel_b_y = res.vby;
   assign rsp_collided    = res.collided;

endmodule
`default_nettype wire

>>> hw/rtl/cci_checker.sv
`default_nettype none
module cci_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [31:0] rsp_new_pos_a_x,
   input wire logic signed [31:0] rsp_new_vel_b_y,
   input wire logic               rsp_collided
);

   // an empty pipe comes out of reset
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // with no word waiting at the output, input is always taken
   a_ready_when_drained : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output");

   // a held result stays put
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_pos_a_x)
         && $stable(rsp_new_vel_b_y) && $stable(rsp_collided))
      else $error("result changed while stalled");

   // once the entry is blocked by a stall it stays blocked until the stall ends
   a_block_holds : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !req_ready |=> !req_ready || rsp_ready)
      else $error("entry reopened during stall");

endmodule

bind circle_collision_impulse_top cci_checker u_cci_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_new_pos_a_x (rsp_new_pos_a_x),
   .rsp_new_vel_b_y (rsp_new_vel_b_y),
   .rsp_collided    (rsp_collided)
);
`default_nettype wire
